// ===== rtl/tpbs_pkg.sv =====
package tpbs_pkg;

    localparam int DEF_MAX_WIDTH       = 256;
    localparam int DEF_MAX_HEIGHT      = 256;
    localparam int DEF_COORD_FRAC_BITS = 16;

    // queue depths, powers of two
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 8;

    localparam int          CFG_DATA_W     = 9;
    localparam logic [8:0]  TEX_SIZE_RESET = 9'd256;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_POINT  = 2'd1,
        REQ_BILIN  = 2'd2,
        REQ_UNUSED = 2'd3
    } t_req;

    typedef enum logic [0:0] {
        REG_TEX_WIDTH  = 1'b0,
        REG_TEX_HEIGHT = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic                  we;
        t_reg_idx              index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/tpbs_fifo.sv =====
module tpbs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_empty = (r_count == '0);
    assign do_pop  = i_pop && !o_empty;
    assign do_push = i_push;
    assign o_data  = r_mem[r_rd_ptr];
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) r_wr_ptr <= r_wr_ptr + PW'(1);
            if (do_pop)  r_rd_ptr <= r_rd_ptr + PW'(1);
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

// ===== rtl/tpbs_front.sv =====
module tpbs_front #(
    parameter int MAX_WIDTH       = tpbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = tpbs_pkg::DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = tpbs_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  tpbs_pkg::t_cfg_wr                          i_cfg,
    input  logic                                       i_push,
    output logic                                       o_full,
    input  logic [1:0]                                 i_req_type,
    input  logic [7:0]                                 i_texel_x,
    input  logic [7:0]                                 i_texel_y,
    input  logic [23:0]                                i_rgb,
    input  logic [COORD_FRAC_BITS:0]                   i_coord_u,
    input  logic [COORD_FRAC_BITS:0]                   i_coord_v,
    input  logic [$clog2(tpbs_pkg::MID_DEPTH+1)-1:0]   i_mid_count,
    output logic                                       o_valid,
    output logic                                       o_is_write,
    output logic [$clog2(MAX_WIDTH)-1:0]               o_x,
    output logic [$clog2(MAX_HEIGHT)-1:0]              o_y,
    output logic [COORD_FRAC_BITS-1:0]                 o_fu,
    output logic [COORD_FRAC_BITS-1:0]                 o_fv,
    output logic [23:0]                                o_rgb,
    output logic                                       o_flag
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int XB  = $clog2(MAX_WIDTH);
    localparam int YB  = $clog2(MAX_HEIGHT);
    localparam int SWB = $clog2(MAX_WIDTH+1);
    localparam int SHB = $clog2(MAX_HEIGHT+1);
    localparam int PUW = F + 1 + SWB;
    localparam int PVW = F + 1 + SHB;
    localparam int MCW = $clog2(tpbs_pkg::MID_DEPTH+1);
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic [tpbs_pkg::CFG_DATA_W-1:0] r_tex_width, r_tex_height;
    logic [SWB-1:0] w_use, scale_u;
    logic [SHB-1:0] h_use, scale_v;
    logic [F:0]     u_c, v_c;
    logic           accept, keep, is_point, x_ok, y_ok, clamp_hit;

    logic           r_valid, r_is_write, r_is_point, r_flag;
    logic [PUW-1:0] r_prod_u;
    logic [PVW-1:0] r_prod_v;
    logic [7:0]     r_wx, r_wy;
    logic [23:0]    r_rgb;
    logic [PUW:0]   s_u;
    logic [PVW:0]   s_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_width  <= tpbs_pkg::TEX_SIZE_RESET;
            r_tex_height <= tpbs_pkg::TEX_SIZE_RESET;
        end else if (i_cfg.we) begin
            unique case (i_cfg.index)
                tpbs_pkg::REG_TEX_WIDTH:  r_tex_width  <= i_cfg.data;
                tpbs_pkg::REG_TEX_HEIGHT: r_tex_height <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_tex_width < 9'd2)                       w_use = SWB'(2);
        else if (32'(r_tex_width) > MAX_WIDTH)        w_use = SWB'(MAX_WIDTH);
        else                                          w_use = SWB'(r_tex_width);
        if (r_tex_height < 9'd2)                      h_use = SHB'(2);
        else if (32'(r_tex_height) > MAX_HEIGHT)      h_use = SHB'(MAX_HEIGHT);
        else                                          h_use = SHB'(r_tex_height);
    end

    always_comb begin
        keep     = 1'b0;
        is_point = 1'b0;
        unique case (tpbs_pkg::t_req'(i_req_type))
            tpbs_pkg::REQ_WRITE: keep = x_ok && y_ok;
            tpbs_pkg::REQ_POINT: begin
                keep     = 1'b1;
                is_point = 1'b1;
            end
            tpbs_pkg::REQ_BILIN: keep = 1'b1;
            default:             keep = 1'b0;
        endcase
    end

    assign x_ok      = 32'(i_texel_x) < MAX_WIDTH;
    assign y_ok      = 32'(i_texel_y) < MAX_HEIGHT;
    assign u_c       = (i_coord_u > ONE) ? ONE : i_coord_u;
    assign v_c       = (i_coord_v > ONE) ? ONE : i_coord_v;
    assign clamp_hit = (i_coord_u > ONE) || (i_coord_v > ONE);
    assign scale_u   = is_point ? w_use - SWB'(1) : w_use - SWB'(2);
    assign scale_v   = is_point ? h_use - SHB'(1) : h_use - SHB'(2);

    // reserve a slot in the queue for the word held here
    assign o_full = ((MCW+1)'(i_mid_count) + (MCW+1)'(r_valid)) >=
                    (MCW+1)'(tpbs_pkg::MID_DEPTH);
    assign accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= accept && keep;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_is_write <= (tpbs_pkg::t_req'(i_req_type) == tpbs_pkg::REQ_WRITE);
            r_is_point <= is_point;
            r_flag     <= clamp_hit;
            r_prod_u   <= PUW'(u_c) * PUW'(scale_u);
            r_prod_v   <= PVW'(v_c) * PVW'(scale_v);
            r_wx       <= i_texel_x;
            r_wy       <= i_texel_y;
            r_rgb      <= i_rgb;
        end
    end

    // round by half a texel, then split integer and fraction
    assign s_u = (PUW+1)'(r_prod_u) + (PUW+1)'(ONE >> 1);
    assign s_v = (PVW+1)'(r_prod_v) + (PVW+1)'(ONE >> 1);

    assign o_valid    = r_valid;
    assign o_is_write = r_is_write;
    assign o_x        = r_is_write ? XB'(r_wx) : s_u[F +: XB];
    assign o_y        = r_is_write ? YB'(r_wy) : s_v[F +: YB];
    assign o_fu       = r_is_point ? '0 : s_u[F-1:0];
    assign o_fv       = r_is_point ? '0 : s_v[F-1:0];
    assign o_rgb      = r_rgb;
    assign o_flag     = r_flag;

endmodule

// ===== rtl/tpbs_back.sv =====
module tpbs_back #(
    parameter int MAX_WIDTH       = tpbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = tpbs_pkg::DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = tpbs_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_mid_empty,
    input  logic                                       i_is_write,
    input  logic [$clog2(MAX_WIDTH)-1:0]               i_x,
    input  logic [$clog2(MAX_HEIGHT)-1:0]              i_y,
    input  logic [COORD_FRAC_BITS-1:0]                 i_fu,
    input  logic [COORD_FRAC_BITS-1:0]                 i_fv,
    input  logic [23:0]                                i_rgb,
    input  logic                                       i_flag,
    input  logic [$clog2(tpbs_pkg::OUT_DEPTH+1)-1:0]   i_out_count,
    output logic                                       o_mid_pop,
    output logic                                       o_valid,
    output logic [15:0]                                o_red,
    output logic [15:0]                                o_green,
    output logic [15:0]                                o_blue,
    output logic                                       o_flag
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int XB  = $clog2(MAX_WIDTH);
    localparam int YB  = $clog2(MAX_HEIGHT);
    localparam int CB  = (XB > 1) ? XB - 1 : 1;
    localparam int RB  = (YB > 1) ? YB - 1 : 1;
    localparam int BANK_DEPTH = 1 << (CB + RB);
    localparam int WW  = 2*F + 1;
    localparam int PW  = 2*F + 8;
    localparam int OCW = $clog2(tpbs_pkg::OUT_DEPTH+1);
    localparam logic [F:0] ONE = {1'b1, {F{1'b0}}};

    logic          issue_write, issue_samp, credit;
    logic [XB:0]   ux;
    logic [YB:0]   vy;
    logic [CB-1:0] col_even, col_odd, wcol;
    logic [RB-1:0] row_even, row_odd, wrow;
    logic [F:0]    a0, a1, b0, b1;
    logic [2*F+1:0] w_full [4];

    logic [23:0]   r_rd [4];
    logic [WW-1:0] r_w [4];
    logic          r_v1, r_v2, r_pu, r_pv, r_flag1, r_flag2;
    logic [PW-1:0] r_p [3][4];
    logic [23:0]   tex [4];
    logic [PW-1:0] acc [3];

    // a sample issues only with room in the result queue for all in flight
    assign credit = ((OCW+2)'(i_out_count) + (OCW+2)'(r_v1) + (OCW+2)'(r_v2)) <
                    (OCW+2)'(tpbs_pkg::OUT_DEPTH);
    assign issue_write = !i_mid_empty && i_is_write;
    assign issue_samp  = !i_mid_empty && !i_is_write && credit;
    assign o_mid_pop   = issue_write || issue_samp;

    // even bank holds x or x+1 whichever is even, odd bank the other
    assign ux       = {1'b0, i_x};
    assign vy       = {1'b0, i_y};
    assign col_even = CB'((ux + (XB+1)'(1)) >> 1);
    assign col_odd  = CB'(ux >> 1);
    assign row_even = RB'((vy + (YB+1)'(1)) >> 1);
    assign row_odd  = RB'(vy >> 1);
    assign wcol     = CB'(ux >> 1);
    assign wrow     = RB'(vy >> 1);

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [23:0]      mem [BANK_DEPTH];
        logic [CB-1:0]    rcol;
        logic [RB-1:0]    rrow;
        logic             we;
        assign rcol = b[0] ? col_odd : col_even;
        assign rrow = b[1] ? row_odd : row_even;
        assign we   = issue_write && (i_x[0] == b[0]) && (i_y[0] == b[1]);
        always_ff @(posedge i_clk) begin
            if (we)         mem[{wrow, wcol}] <= i_rgb;
            if (issue_samp) r_rd[b] <= mem[{rrow, rcol}];
        end
    end

    assign a1 = {1'b0, i_fu};
    assign a0 = ONE - a1;
    assign b1 = {1'b0, i_fv};
    assign b0 = ONE - b1;
    assign w_full[0] = (2*F+2)'(a0) * (2*F+2)'(b0);
    assign w_full[1] = (2*F+2)'(a1) * (2*F+2)'(b0);
    assign w_full[2] = (2*F+2)'(a0) * (2*F+2)'(b1);
    assign w_full[3] = (2*F+2)'(a1) * (2*F+2)'(b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= issue_samp;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue_samp) begin
            r_pu    <= i_x[0];
            r_pv    <= i_y[0];
            r_flag1 <= i_flag;
            for (int k = 0; k < 4; k++) r_w[k] <= w_full[k][WW-1:0];
        end
    end

    // neighbor k: bit 0 steps right, bit 1 steps down; drop a neighbor with no weight
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            tex[k] = (r_w[k] == '0) ? 24'd0 : r_rd[{r_pv ^ k[1], r_pu ^ k[0]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_flag2 <= r_flag1;
            for (int c = 0; c < 3; c++) begin
                for (int k = 0; k < 4; k++) begin
                    r_p[c][k] <= PW'(tex[k][(23 - 8*c) -: 8]) * PW'(r_w[k]);
                end
            end
        end
    end

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            acc[c] = r_p[c][0] + r_p[c][1] + r_p[c][2] + r_p[c][3] +
                     (PW'(1) << (2*F - 9));
        end
    end

    assign o_valid = r_v2;
    assign o_red   = acc[0][(2*F-8) +: 16];
    assign o_green = acc[1][(2*F-8) +: 16];
    assign o_blue  = acc[2][(2*F-8) +: 16];
    assign o_flag  = r_flag2;

endmodule

// ===== rtl/texture_point_bilinear_sampler.sv =====
// A sample word passes the front register, mid queue, bank read and product registers to
// the output queue, one word per cycle unless a queue is full; the four neighbor texels
// come from four parity banks read in the same cycle, and weight and blend stages are
// fully pipelined. Writes and dropped requests give no result and take a slot each.
// Reset (synchronous, active low) clears queues and pipeline valids and sets both
// size registers to 256; texel banks are not cleared and hold nothing until written.
module texture_point_bilinear_sampler #(
    parameter int MAX_WIDTH       = tpbs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT      = tpbs_pkg::DEF_MAX_HEIGHT,
    parameter int COORD_FRAC_BITS = tpbs_pkg::DEF_COORD_FRAC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [0:0]                 i_cfg_index,
    input  logic [8:0]                 i_cfg_data,
    input  logic                       push,
    output logic                       full,
    input  logic [1:0]                 i_req_type,
    input  logic [7:0]                 i_texel_x,
    input  logic [7:0]                 i_texel_y,
    input  logic [7:0]                 i_texel_red,
    input  logic [7:0]                 i_texel_green,
    input  logic [7:0]                 i_texel_blue,
    input  logic [COORD_FRAC_BITS:0]   i_coord_u,
    input  logic [COORD_FRAC_BITS:0]   i_coord_v,
    output logic                       empty,
    input  logic                       pop,
    output logic [15:0]                o_red_out,
    output logic [15:0]                o_green_out,
    output logic [15:0]                o_blue_out,
    output logic                       o_coord_clamped
);

    localparam int F   = COORD_FRAC_BITS;
    localparam int XB  = $clog2(MAX_WIDTH);
    localparam int YB  = $clog2(MAX_HEIGHT);
    localparam int MW  = 1 + XB + YB + 2*F + 24 + 1;
    localparam int OW  = 16*3 + 1;
    localparam int MCW = $clog2(tpbs_pkg::MID_DEPTH+1);
    localparam int OCW = $clog2(tpbs_pkg::OUT_DEPTH+1);

    tpbs_pkg::t_cfg_wr cfg;

    logic          f_valid, f_is_write, f_flag;
    logic [XB-1:0] f_x;
    logic [YB-1:0] f_y;
    logic [F-1:0]  f_fu, f_fv;
    logic [23:0]   f_rgb;

    logic [MW-1:0]  mid_in, mid_out;
    logic           mid_empty, mid_pop;
    logic [MCW-1:0] mid_count;

    logic          h_is_write, h_flag;
    logic [XB-1:0] h_x;
    logic [YB-1:0] h_y;
    logic [F-1:0]  h_fu, h_fv;
    logic [23:0]   h_rgb;

    logic           b_valid, b_flag;
    logic [15:0]    b_red, b_green, b_blue;
    logic [OW-1:0]  out_in, out_data;
    logic [OCW-1:0] out_count;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = tpbs_pkg::t_reg_idx'(i_cfg_index);
    assign cfg.data  = i_cfg_data;

    tpbs_front #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_push      (push),
        .o_full      (full),
        .i_req_type  (i_req_type),
        .i_texel_x   (i_texel_x),
        .i_texel_y   (i_texel_y),
        .i_rgb       ({i_texel_red, i_texel_green, i_texel_blue}),
        .i_coord_u   (i_coord_u),
        .i_coord_v   (i_coord_v),
        .i_mid_count (mid_count),
        .o_valid     (f_valid),
        .o_is_write  (f_is_write),
        .o_x         (f_x),
        .o_y         (f_y),
        .o_fu        (f_fu),
        .o_fv        (f_fv),
        .o_rgb       (f_rgb),
        .o_flag      (f_flag)
    );

    assign mid_in = {f_is_write, f_x, f_y, f_fu, f_fv, f_rgb, f_flag};

    tpbs_fifo #(
        .WIDTH (MW),
        .DEPTH (tpbs_pkg::MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (mid_in),
        .i_pop   (mid_pop),
        .o_data  (mid_out),
        .o_empty (mid_empty),
        .o_count (mid_count)
    );

    assign {h_is_write, h_x, h_y, h_fu, h_fv, h_rgb, h_flag} = mid_out;

    tpbs_back #(
        .MAX_WIDTH       (MAX_WIDTH),
        .MAX_HEIGHT      (MAX_HEIGHT),
        .COORD_FRAC_BITS (COORD_FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_empty (mid_empty),
        .i_is_write  (h_is_write),
        .i_x         (h_x),
        .i_y         (h_y),
        .i_fu        (h_fu),
        .i_fv        (h_fv),
        .i_rgb       (h_rgb),
        .i_flag      (h_flag),
        .i_out_count (out_count),
        .o_mid_pop   (mid_pop),
        .o_valid     (b_valid),
        .o_red       (b_red),
        .o_green     (b_green),
        .o_blue      (b_blue),
        .o_flag      (b_flag)
    );

    assign out_in = {b_red, b_green, b_blue, b_flag};

    tpbs_fifo #(
        .WIDTH (OW),
        .DEPTH (tpbs_pkg::OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid),
        .i_data  (out_in),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_count (out_count)
    );

    assign {o_red_out, o_green_out, o_blue_out, o_coord_clamped} = out_data;

endmodule

// ===== dv/tb_texture_point_bilinear_sampler.sv =====
module tb_texture_point_bilinear_sampler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = tpbs_pkg::DEF_COORD_FRAC_BITS;
    localparam int WMAX = tpbs_pkg::DEF_MAX_WIDTH;
    localparam int HMAX = tpbs_pkg::DEF_MAX_HEIGHT;
    localparam longint unsigned ONE = 64'd1 << FRAC;
    localparam longint unsigned HALF = ONE >> 1;
    localparam logic [FRAC:0] C_ONE  = {1'b1, {FRAC{1'b0}}};
    localparam logic [FRAC:0] C_HALF = C_ONE >> 1;
    localparam logic [FRAC:0] C_MAX  = '1;
    localparam int ITEMS_PER_PHASE = 105;

    typedef struct {
        logic [1:0]    req;
        logic [7:0]    x, y, r, g, b;
        logic [FRAC:0] u, v;
    } t_word;

    typedef struct {
        logic [15:0] red, green, blue;
        logic        clamped;
    } t_color;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    tpbs_pkg::t_reg_idx i_cfg_index = tpbs_pkg::REG_TEX_WIDTH;
    logic [8:0]         i_cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic [1:0]         i_req_type = '0;
    logic [7:0]         i_texel_x = '0, i_texel_y = '0;
    logic [7:0]         i_texel_red = '0, i_texel_green = '0, i_texel_blue = '0;
    logic [FRAC:0]      i_coord_u = '0, i_coord_v = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [15:0]        o_red_out, o_green_out, o_blue_out;
    logic               o_coord_clamped;

    texture_point_bilinear_sampler dut (.*);

    // pending words for the driver, expected colors for the monitor
    t_word   words_q[$];
    t_color  colors_q[$];

    // model state, updated at the accepting edge
    logic [23:0] texel_mem [WMAX*HMAX];
    logic [8:0]  model_w = 9'd256, model_h = 9'd256;

    // generator view: which texels will have been written
    bit          planned [WMAX*HMAX];
    logic [8:0]  gen_w = 9'd256, gen_h = 9'd256;

    int  idle_push = 0, idle_pop = 0;
    bit  in_acc = 1'b0;
    int  mismatches = 0;
    int  n_write = 0, n_point = 0, n_bilin = 0, n_clamped = 0, n_skip = 0, n_cfg = 0;

    initial forever #10 i_clk = ~i_clk;

    function automatic int used_size(logic [8:0] reg_val, int max_size);
        if (reg_val < 2) return 2;
        if (reg_val > max_size) return max_size;
        return int'(reg_val);
    endfunction

    function automatic longint unsigned clamp_coord(logic [FRAC:0] c, inout bit flag);
        if (c > ONE) begin
            flag = 1'b1;
            return ONE;
        end
        return 64'(c);
    endfunction

    function automatic int nearest(longint unsigned c, int size);
        return int'((c * longint'(size - 1) + HALF) >> FRAC);
    endfunction

    function automatic longint unsigned bilin_pos(longint unsigned c, int size);
        return c * longint'(size - 2) + HALF;
    endfunction

    // compute the filtered color of a sample word against the model store
    function automatic t_color sample_color(t_word wd);
        t_color res;
        bit flag = 1'b0;
        longint unsigned u, v, su, sv, fu, fv;
        longint unsigned wt [4];
        longint unsigned acc;
        logic [23:0] tx [4];
        int w, h, x0, y0;
        w = used_size(model_w, WMAX);
        h = used_size(model_h, HMAX);
        u = clamp_coord(wd.u, flag);
        v = clamp_coord(wd.v, flag);
        if (wd.req == tpbs_pkg::REQ_POINT) begin
            tx[0] = texel_mem[nearest(v, h) * WMAX + nearest(u, w)];
            res.red   = {tx[0][23:16], 8'h00};
            res.green = {tx[0][15:8], 8'h00};
            res.blue  = {tx[0][7:0], 8'h00};
        end else begin
            su = bilin_pos(u, w);
            sv = bilin_pos(v, h);
            x0 = int'(su >> FRAC);
            y0 = int'(sv >> FRAC);
            fu = su & (ONE - 1);
            fv = sv & (ONE - 1);
            wt[0] = (ONE - fu) * (ONE - fv);
            wt[1] = fu * (ONE - fv);
            wt[2] = (ONE - fu) * fv;
            wt[3] = fu * fv;
            tx[0] = texel_mem[y0 * WMAX + x0];
            tx[1] = texel_mem[y0 * WMAX + x0 + 1];
            tx[2] = texel_mem[(y0 + 1) * WMAX + x0];
            tx[3] = texel_mem[(y0 + 1) * WMAX + x0 + 1];
            for (int ch = 0; ch < 3; ch++) begin
                acc = 0;
                for (int k = 0; k < 4; k++)
                    acc += longint'((tx[k] >> (16 - 8 * ch)) & 24'hff) * wt[k];
                acc = (acc + (64'd1 << (2 * FRAC - 9))) >> (2 * FRAC - 8);
                if (ch == 0) res.red = acc[15:0];
                else if (ch == 1) res.green = acc[15:0];
                else res.blue = acc[15:0];
            end
        end
        res.clamped = flag;
        return res;
    endfunction

    function automatic void plan_write(int x, int y, int r, int g, int b);
        t_word wd;
        wd.req = tpbs_pkg::REQ_WRITE;
        wd.x = 8'(x); wd.y = 8'(y); wd.r = 8'(r); wd.g = 8'(g); wd.b = 8'(b);
        wd.u = (FRAC+1)'($urandom); wd.v = (FRAC+1)'($urandom);
        planned[y * WMAX + x] = 1'b1;
        words_q.push_back(wd);
    endfunction

    function automatic void plan_fill(int x, int y);
        if (!planned[y * WMAX + x])
            plan_write(x, y, $urandom_range(255), $urandom_range(255), $urandom_range(255));
    endfunction

    // queue a sample, preceded by writes of any texel it reads that was never written
    function automatic void plan_sample(logic [1:0] req, logic [FRAC:0] cu, logic [FRAC:0] cv);
        t_word wd;
        bit flag = 1'b0;
        longint unsigned u, v;
        int w, h, x0, y0;
        w = used_size(gen_w, WMAX);
        h = used_size(gen_h, HMAX);
        u = clamp_coord(cu, flag);
        v = clamp_coord(cv, flag);
        if (req == tpbs_pkg::REQ_POINT) begin
            plan_fill(nearest(u, w), nearest(v, h));
        end else begin
            x0 = int'(bilin_pos(u, w) >> FRAC);
            y0 = int'(bilin_pos(v, h) >> FRAC);
            plan_fill(x0, y0);
            plan_fill(x0 + 1, y0);
            plan_fill(x0, y0 + 1);
            plan_fill(x0 + 1, y0 + 1);
        end
        wd.req = req;
        wd.x = 8'($urandom); wd.y = 8'($urandom);
        wd.r = 8'($urandom); wd.g = 8'($urandom); wd.b = 8'($urandom);
        wd.u = cu; wd.v = cv;
        words_q.push_back(wd);
    endfunction

    function automatic void plan_unused();
        t_word wd;
        wd.req = tpbs_pkg::REQ_UNUSED;
        wd.x = 8'($urandom); wd.y = 8'($urandom);
        wd.r = 8'($urandom); wd.g = 8'($urandom); wd.b = 8'($urandom);
        wd.u = (FRAC+1)'($urandom); wd.v = (FRAC+1)'($urandom);
        words_q.push_back(wd);
    endfunction

    function automatic logic [FRAC:0] rand_coord();
        case ($urandom_range(9))
            0:       return (FRAC+1)'($urandom_range(32'(2 * ONE - 1), 32'(ONE + 1)));
            1:       return '0;
            2:       return C_ONE;
            default: return (FRAC+1)'($urandom_range(32'(ONE)));
        endcase
    endfunction

    // driver: hold a word until taken, else offer the next one
    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= idle_pop);
        if (!(push && !in_acc)) begin
            if (words_q.size() > 0 && $urandom_range(99) >= idle_push) begin
                push          <= 1'b1;
                i_req_type    <= words_q[0].req;
                i_texel_x     <= words_q[0].x;
                i_texel_y     <= words_q[0].y;
                i_texel_red   <= words_q[0].r;
                i_texel_green <= words_q[0].g;
                i_texel_blue  <= words_q[0].b;
                i_coord_u     <= words_q[0].u;
                i_coord_v     <= words_q[0].v;
            end else begin
                push <= 1'b0;
            end
        end
    end

    // monitor: apply accepted words and writes to the model, check each result
    always @(posedge i_clk) begin
        t_word  wd;
        t_color exp_c;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_index == tpbs_pkg::REG_TEX_WIDTH) model_w = i_cfg_data;
                else model_h = i_cfg_data;
            end
            in_acc <= push && !full;
            if (push && !full) begin
                wd = words_q.pop_front();
                case (wd.req)
                    tpbs_pkg::REQ_WRITE: texel_mem[wd.y * WMAX + wd.x] = {wd.r, wd.g, wd.b};
                    tpbs_pkg::REQ_POINT, tpbs_pkg::REQ_BILIN: begin
                        exp_c = sample_color(wd);
                        colors_q.push_back(exp_c);
                        if (exp_c.clamped) n_clamped++;
                    end
                    default: ;
                endcase
            end
            if (pop && !empty) begin
                if (colors_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("ERROR: unexpected word r=%h g=%h b=%h c=%b",
                                 o_red_out, o_green_out, o_blue_out, o_coord_clamped);
                end else begin
                    exp_c = colors_q.pop_front();
                    if (o_red_out !== exp_c.red || o_green_out !== exp_c.green ||
                        o_blue_out !== exp_c.blue || o_coord_clamped !== exp_c.clamped) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("ERROR: exp r=%h g=%h b=%h c=%b got r=%h g=%h b=%h c=%b",
                                     exp_c.red, exp_c.green, exp_c.blue, exp_c.clamped,
                                     o_red_out, o_green_out, o_blue_out, o_coord_clamped);
                    end
                end
            end
        end
    end

    task automatic write_size(tpbs_pkg::t_reg_idx idx, logic [8:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == tpbs_pkg::REG_TEX_WIDTH) gen_w = val;
        else gen_h = val;
        n_cfg++;
    endtask

    // hold off until every word is taken and every result is back
    task automatic drain();
        while (words_q.size() > 0) @(posedge i_clk);
        while (colors_q.size() > 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    initial begin
        logic [8:0] sizes [9][2] = '{
            '{9'd256, 9'd256}, '{9'd2, 9'd2}, '{9'd0, 9'd1}, '{9'd5, 9'd3},
            '{9'd16, 9'd9}, '{9'd511, 9'd300}, '{9'd37, 9'd200}, '{9'd3, 9'd256},
            '{9'd256, 9'd256}};
        int base;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        for (int ph = 0; ph < 9; ph++) begin
            idle_push = (ph < 3) ? 37 : (ph < 6) ? 65 : 0;
            idle_pop  = (ph < 3) ? 65 : (ph < 6) ? 37 : 0;
            write_size(tpbs_pkg::REG_TEX_WIDTH, sizes[ph][0]);
            write_size(tpbs_pkg::REG_TEX_HEIGHT, sizes[ph][1]);
            if (ph == 0) begin
                plan_write(0, 0, 0, 0, 0);
                plan_write(255, 255, 255, 255, 255);
                plan_write(255, 0, 8'haa, 8'h55, 8'hff);
                plan_write(0, 255, 8'h55, 8'haa, 8'h00);
                plan_sample(tpbs_pkg::REQ_POINT, '0, '0);
                plan_sample(tpbs_pkg::REQ_POINT, C_ONE, C_ONE);
                plan_sample(tpbs_pkg::REQ_POINT, C_ONE, '0);
                plan_sample(tpbs_pkg::REQ_BILIN, '0, '0);
                plan_sample(tpbs_pkg::REQ_BILIN, C_ONE, C_ONE);
                plan_sample(tpbs_pkg::REQ_BILIN, C_HALF, C_HALF);
                plan_sample(tpbs_pkg::REQ_POINT, C_MAX, C_HALF);
                plan_sample(tpbs_pkg::REQ_BILIN, C_HALF, C_MAX);
                plan_sample(tpbs_pkg::REQ_BILIN, C_MAX, C_MAX);
                words_q.push_back('{tpbs_pkg::REQ_UNUSED, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
                                    C_MAX, C_MAX});
                n_skip++;
            end
            base = words_q.size();
            while (words_q.size() - base < ITEMS_PER_PHASE) begin
                case ($urandom_range(19))
                    0, 1, 2, 3: plan_write($urandom_range(255), $urandom_range(255),
                                           $urandom_range(255), $urandom_range(255),
                                           $urandom_range(255));
                    4: begin
                        plan_unused();
                        base++;
                        n_skip++;
                    end
                    5, 6, 7, 8, 9, 10, 11:
                        plan_sample(tpbs_pkg::REQ_POINT, rand_coord(), rand_coord());
                    default: plan_sample(tpbs_pkg::REQ_BILIN, rand_coord(), rand_coord());
                endcase
            end
            foreach (words_q[i]) begin
                if (words_q[i].req == tpbs_pkg::REQ_WRITE) n_write++;
                else if (words_q[i].req == tpbs_pkg::REQ_POINT) n_point++;
                else if (words_q[i].req == tpbs_pkg::REQ_BILIN) n_bilin++;
            end
            drain();
        end
        $display("Covered %0d texel writes, %0d point and %0d bilinear samples (%0d clamped),",
                 n_write, n_point, n_bilin, n_clamped);
        $display("%0d ignored requests and %0d size register writes; %0d mismatches.",
                 n_skip, n_cfg, mismatches);
        if (mismatches == 0 && colors_q.size() == 0)
            $display("PASS texture_point_bilinear_sampler");
        else
            $display("FAIL texture_point_bilinear_sampler");
        $finish;
    end

    initial begin
        #(20ns * 600000);
        $display("ERROR: timeout");
        $display("FAIL texture_point_bilinear_sampler");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tpbs_pkg.sv
rtl/tpbs_fifo.sv
rtl/tpbs_front.sv
rtl/tpbs_back.sv
rtl/texture_point_bilinear_sampler.sv
dv/tb_texture_point_bilinear_sampler.sv
